@@ src/cidh_pkg.sv @@
package cidh_pkg;

  localparam int ID_W        = 11;
  localparam int HND_W       = 8;
  localparam int DATA_W      = 64;
  localparam int STATUS_W    = 3;
  localparam int SLOT_OUT_W  = 4;
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 3;
  localparam int RECIP_SHIFT = 20;

  localparam logic [STATUS_W-1:0] ST_REGISTERED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELIVERED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_HANDLER = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd5;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic hash_mul;
    logic hash_mod;
    logic set_skip;
    logic probe_start;
    logic probe_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic skip;
    logic probe_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

@@ src/can_id_dispatch_hash_table.sv @@
// CAN identifier dispatch table: per-bus open-addressing hash of standard
// identifiers to handler numbers, probed linearly from (id mod TABLE_SLOTS).
// Input stream s_axis: tuser selects register (cmd 0) or dispatch (cmd 1),
// the bus and the frame flags; tdata carries identifier, handler, payload.
// Output stream m_axis: one transaction per input, tuser is the status code,
// tdata carries the handler found, the slot and the forwarded payload.
// One item is in work at a time. An item probes k slots (1 to
// TABLE_SLOTS); from one input transaction to the next it passes through
// the hash (reciprocal multiply, then remainder), the issue of the first
// table read, a compare for each probed slot on the single table read
// port, and the load of the output register. Ignored frames and items
// for an absent bus skip the remainder, the first read and the probe.
// After reset the table valid marks are cleared by a pass over all
// BUS_COUNT * TABLE_SLOTS entries, one entry per cycle; s_axis_tready stays
// low until it ends. The output register holds a result while m_axis_tready
// is low; the next item is still accepted and worked on, and waits for the
// output register before its result is loaded.
module can_id_dispatch_hash_table #(
  parameter int TABLE_SLOTS = 16,
  parameter int BUS_COUNT   = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // frame_id[10:0], handler[18:11], payload[82:19], zero[87:83]
  input  logic [cidh_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd[0], bus[1], is_extended[2], is_remote[3]
  input  logic [cidh_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // target_handler[7:0], slot_used[11:8], payload_out[75:12], zero[79:76]
  output logic [cidh_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status[2:0]
  output logic [cidh_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import cidh_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  cidh_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cmd           (cmd),
    .stat          (stat)
  );

  cidh_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .BUS_COUNT   (BUS_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

@@ src/cidh_ctrl.sv @@
module cidh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  output cidh_pkg::ctrl_cmd_t cmd,
  input  cidh_pkg::ctrl_stat_t stat
);
  import cidh_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR       = 7'b0000001,
    S_IDLE        = 7'b0000010,
    S_HASH_MUL    = 7'b0000100,
    S_HASH_MOD    = 7'b0001000,
    S_PROBE_START = 7'b0010000,
    S_PROBE       = 7'b0100000,
    S_EMIT        = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_HASH_MUL;
        end
      end
      S_HASH_MUL: begin
        cmd.hash_mul = 1'b1;
        if (stat.skip) begin
          cmd.set_skip = 1'b1;
          state_next   = S_EMIT;
        end else begin
          state_next = S_HASH_MOD;
        end
      end
      S_HASH_MOD: begin
        cmd.hash_mod = 1'b1;
        state_next   = S_PROBE_START;
      end
      S_PROBE_START: begin
        cmd.probe_start = 1'b1;
        state_next      = S_PROBE;
      end
      S_PROBE: begin
        cmd.probe_step = 1'b1;
        if (stat.probe_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

@@ src/cidh_datapath.sv @@
module cidh_datapath #(
  parameter int TABLE_SLOTS = 16,
  parameter int BUS_COUNT   = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [cidh_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic [cidh_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cidh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic [cidh_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  input  cidh_pkg::ctrl_cmd_t                 cmd,
  output cidh_pkg::ctrl_stat_t                stat
);
  import cidh_pkg::*;

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int DEPTH  = BUS_COUNT * TABLE_SLOTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RECIP  = (1 << RECIP_SHIFT) / TABLE_SLOTS;
  localparam int PROD_W = ID_W + RECIP_SHIFT;
  localparam int MOD_W  = ID_W + SLOT_W + 1;
  localparam int ENT_W  = 1 + ID_W + HND_W;

  logic              op_r;
  logic              bus_r;
  logic [ID_W-1:0]   id_r;
  logic [HND_W-1:0]  hnd_r;
  logic              ext_r;
  logic              rtr_r;
  logic [DATA_W-1:0] payload_r;

  logic [PROD_W-1:0] prod_r;
  logic [SLOT_W-1:0] cmp_slot;
  logic [SLOT_W-1:0] cnt;
  logic [ADDR_W-1:0] clr_addr;

  logic [ENT_W-1:0]  mem [DEPTH];
  logic [ENT_W-1:0]  mem_q;

  logic [STATUS_W-1:0]   res_status;
  logic [HND_W-1:0]      res_hnd;
  logic [SLOT_OUT_W-1:0] res_slot;
  logic                  res_deliver;

  logic [ID_W-1:0]   quot;
  logic [MOD_W-1:0]  qt;
  logic [MOD_W-1:0]  diff;
  logic [MOD_W-1:0]  rem;
  logic [SLOT_W-1:0] next_slot;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] slot_addr;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [ENT_W-1:0]  wd;

  logic              ent_valid;
  logic [ID_W-1:0]   ent_id;
  logic [HND_W-1:0]  ent_hnd;
  logic              id_eq;
  logic              last_probe;
  logic              reg_hit;
  logic              bus_absent;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

  assign bus_absent = !(int'(bus_r) < BUS_COUNT);
  assign base       = ADDR_W'(int'(bus_r) * TABLE_SLOTS);

  assign quot = prod_r[PROD_W-1:RECIP_SHIFT];
  assign qt   = MOD_W'(quot) * MOD_W'(TABLE_SLOTS);
  assign diff = MOD_W'(id_r) - qt;
  assign rem  = (diff >= MOD_W'(TABLE_SLOTS)) ? diff - MOD_W'(TABLE_SLOTS) : diff;

  assign next_slot = (cmp_slot == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : cmp_slot + 1'b1;
  assign slot_addr = base + ADDR_W'(cmp_slot);
  assign rd_addr   = base + ADDR_W'(cmd.probe_step ? next_slot : cmp_slot);

  assign ent_valid  = mem_q[ENT_W-1];
  assign ent_id     = mem_q[HND_W +: ID_W];
  assign ent_hnd    = mem_q[HND_W-1:0];
  assign id_eq      = (ent_id == id_r);
  assign last_probe = (cnt == SLOT_W'(TABLE_SLOTS - 1));
  assign reg_hit    = (op_r == OP_REGISTER) && (!ent_valid || id_eq);
  assign slot_ext   = {{SLOT_OUT_W{1'b0}}, cmp_slot};

  assign we = cmd.clear_step || (cmd.probe_step && reg_hit);
  assign wa = cmd.clear_step ? clr_addr : slot_addr;
  assign wd = cmd.clear_step ? '0 : {1'b1, id_r, hnd_r};

  assign stat.clear_last = (clr_addr == ADDR_W'(DEPTH - 1));
  assign stat.skip       = bus_absent || ((op_r == OP_DISPATCH) && (ext_r || rtr_r));
  assign stat.probe_done = !ent_valid || id_eq || last_probe;
  assign stat.out_free   = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= s_axis_tuser[0];
      bus_r     <= s_axis_tuser[1];
      ext_r     <= s_axis_tuser[2];
      rtr_r     <= s_axis_tuser[3];
      id_r      <= s_axis_tdata[ID_W-1:0];
      hnd_r     <= s_axis_tdata[ID_W +: HND_W];
      payload_r <= s_axis_tdata[ID_W+HND_W +: DATA_W];
    end
    if (cmd.hash_mul) prod_r <= PROD_W'(id_r) * PROD_W'(RECIP);
    if (cmd.hash_mod) cmp_slot <= SLOT_W'(rem);
    if (cmd.probe_start) cnt <= '0;
    if (cmd.probe_step && !stat.probe_done) begin
      cmp_slot <= next_slot;
      cnt      <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_skip) begin
      res_status  <= (op_r == OP_DISPATCH) ? ST_IGNORED : ST_FULL;
      res_hnd     <= '0;
      res_slot    <= '0;
      res_deliver <= 1'b0;
    end else if (cmd.probe_step && stat.probe_done) begin
      res_hnd     <= '0;
      res_slot    <= '0;
      res_deliver <= 1'b0;
      if (op_r == OP_REGISTER) begin
        if (reg_hit) begin
          res_status <= ST_REGISTERED;
          res_slot   <= slot_ext[SLOT_OUT_W-1:0];
        end else begin
          res_status <= ST_FULL;
        end
      end else if (ent_valid && id_eq) begin
        res_slot <= slot_ext[SLOT_OUT_W-1:0];
        if (ent_hnd != '0) begin
          res_status  <= ST_DELIVERED;
          res_hnd     <= ent_hnd;
          res_deliver <= 1'b1;
        end else begin
          res_status <= ST_NO_HANDLER;
        end
      end else begin
        res_status <= ST_NO_MATCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= {
        {(OUT_TDATA_W - DATA_W - SLOT_OUT_W - HND_W){1'b0}},
        (res_deliver ? payload_r : {DATA_W{1'b0}}),
        res_slot,
        res_hnd
      };
    end
  end

endmodule

@@ src/cidh_checker.sv @@
module cidh_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [cidh_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [cidh_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import cidh_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("outputs active after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output transaction changed");

  a_deliver_handler: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_DELIVERED) |-> (m_axis_tdata[7:0] != 8'd0))
    else $error("delivered frame without handler");

  a_payload_gated: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_DELIVERED) |->
      (m_axis_tdata[75:12] == 64'd0) && (m_axis_tdata[7:0] == 8'd0))
    else $error("payload or handler forwarded without delivery");

endmodule

bind can_id_dispatch_hash_table cidh_checker u_cidh_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
